// ----- src/iwm_pkg.sv -----
package iwm_pkg;

  localparam int unsigned CHAR_W = 8;

  // Kind codes of a stored mask position
  localparam logic [1:0] KIND_LIT = 2'd0;
  localparam logic [1:0] KIND_ONE = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_QUEST  = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFS    = 8'h20;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] chr;
  } iwm_entry_t;

  // Per-request control broadcast to every cell
  typedef struct packed {
    logic start;  // load the seed pattern before this request
    logic step;   // consume one name character
    logic upd;    // commit the new active bit
  } iwm_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

// ----- src/iwm_cell.sv -----
module iwm_cell
  import iwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iwm_ctl_t          ctl_i,
  input  logic              we_i,
  input  iwm_entry_t        entry_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              valid_i,
  input  logic              seed_i,
  input  logic              adv_i,
  input  logic              eps_i,
  output logic              adv_o,
  output logic              eps_o,
  output logic              act_o
);

  iwm_entry_t entry_q;
  logic       act_q;
  logic       act_e;
  logic       hit;
  logic       is_run;
  logic       pre;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= entry_i;
    end
  end

  always_comb begin
    act_e  = ctl_i.start ? seed_i : act_q;
    is_run = valid_i && (entry_q.kind == KIND_RUN);
    case (entry_q.kind)
      KIND_LIT: hit = valid_i && (entry_q.chr == char_i);
      KIND_ONE: hit = valid_i;
      KIND_RUN: hit = valid_i;
      default:  hit = 1'b0;
    endcase
    adv_o = ctl_i.step && act_e && hit;
    // a run stays active while it swallows a character
    pre   = adv_i || (ctl_i.step ? (act_e && is_run) : act_e);
    eps_o = pre && is_run;
    act_o = pre || eps_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctl_i.upd) begin
      act_q <= act_o;
    end
  end

endmodule

// ----- src/irc_wildcard_mask_match_unit.sv -----
// Channel  Direction  Signals                                         Accepted when
// -------  ---------  ----------------------------------------------  -------------------------
// in       request    in_valid_i/in_ready_o, req_type_i, char_code_i,  in_valid_i && in_ready_o
//                     is_last_i, is_empty_i
// out      result     out_valid_o/out_ready_i, matched_o,              out_valid_o && out_ready_i
//                     mask_overflow_o
//
// One request per cycle unless a held result stalls input: every mask position cell
// updates in the same cycle, so the throughput is set by the cell row update. A result
// appears in the cycle after the last name request, held in the output register.
// Reset clears all control state; mask entries are undefined until loaded.
// A stalled result blocks input only while the output register is full and not taken.
module irc_wildcard_mask_match_unit
  import iwm_pkg::*;
#(
  parameter int unsigned MASK_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              is_last_i,
  input  logic              is_empty_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              matched_o,
  output logic              mask_overflow_o
);

  localparam int unsigned LW = $clog2(MASK_LEN + 1);

  // Mask loader state. pos_q counts positions as written, len_q counts stored
  // cells: consecutive stars collapse into one cell.
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] pos_q, pos_d;
  logic          esc_q, esc_d;
  logic          ovf_q, ovf_d;
  logic          lrun_q, lrun_d;
  logic          closed_q, closed_d;
  logic          frun_q, frun_d;
  logic          name_q, name_d;

  logic          out_valid_q;
  logic          matched_q;
  logic          ovf_out_q;

  logic          acc;
  logic          wr_en;
  logic [LW-1:0] wr_idx;
  iwm_entry_t    wr_entry;
  iwm_ctl_t      ctl;
  logic [CHAR_W-1:0] fchar;

  logic          adv [MASK_LEN+1];
  logic          eps [MASK_LEN+1];
  logic          act [MASK_LEN+1];
  logic          end_q;
  logic          end_e;
  logic          hit;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign fchar      = fold_char(char_code_i);

  always_comb begin
    logic [LW-1:0] len_e;
    logic [LW-1:0] pos_e;
    logic          store;
    logic [1:0]    kind;

    len_e    = closed_q ? '0 : len_q;
    pos_e    = closed_q ? '0 : pos_q;
    store    = 1'b0;
    kind     = KIND_LIT;
    len_d    = len_q;
    pos_d    = pos_q;
    esc_d    = esc_q;
    ovf_d    = ovf_q;
    lrun_d   = lrun_q;
    closed_d = closed_q;
    frun_d   = frun_q;
    name_d   = name_q;
    wr_en    = 1'b0;
    wr_idx   = len_e;
    wr_entry = '{kind: KIND_LIT, chr: fchar};

    if (acc && !req_type_i) begin
      // mask request: drop any name in progress, restart after a closed mask
      name_d = 1'b0;
      len_d  = len_e;
      pos_d  = pos_e;
      esc_d  = closed_q ? 1'b0 : esc_q;
      ovf_d  = closed_q ? 1'b0 : ovf_q;
      lrun_d = closed_q ? 1'b0 : lrun_q;
      if (!is_empty_i) begin
        if (esc_d) begin
          esc_d = 1'b0;
          store = 1'b1;
          kind  = KIND_LIT;
        end else if (char_code_i == CHAR_BSLASH) begin
          esc_d = 1'b1;
        end else if (char_code_i == CHAR_STAR) begin
          store = 1'b1;
          kind  = KIND_RUN;
        end else if (char_code_i == CHAR_QUEST) begin
          store = 1'b1;
          kind  = KIND_ONE;
        end else begin
          store = 1'b1;
          kind  = KIND_LIT;
        end
      end
      if (store) begin
        if (pos_e == LW'(MASK_LEN)) begin
          ovf_d = 1'b1;
        end else begin
          pos_d = pos_e + LW'(1);
          if (!(kind == KIND_RUN && lrun_d)) begin
            wr_en         = 1'b1;
            wr_entry.kind = kind;
            len_d         = len_e + LW'(1);
            lrun_d        = (kind == KIND_RUN);
            if (len_e == '0) begin
              frun_d = (kind == KIND_RUN);
            end
          end
        end
      end
      closed_d = is_last_i;
      if (is_last_i) begin
        esc_d = 1'b0;
      end
    end else if (acc) begin
      name_d = !is_last_i;
    end
  end

  always_comb begin
    ctl.start = acc && req_type_i && !name_q;
    ctl.step  = acc && req_type_i && !is_empty_i;
    ctl.upd   = acc && req_type_i;
  end

  assign adv[0] = 1'b0;
  assign eps[0] = 1'b0;

  for (genvar g = 0; g < MASK_LEN; g++) begin : g_cell
    logic seed;
    if (g == 0) begin : g_seed0
      assign seed = 1'b1;
    end else if (g == 1) begin : g_seed1
      assign seed = frun_q && (len_q != '0);
    end else begin : g_seedn
      assign seed = 1'b0;
    end

    iwm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .we_i    (wr_en && (wr_idx == LW'(g))),
      .entry_i (wr_entry),
      .char_i  (fchar),
      .valid_i (len_q > LW'(g)),
      .seed_i  (seed),
      .adv_i   (adv[g]),
      .eps_i   (eps[g]),
      .adv_o   (adv[g+1]),
      .eps_o   (eps[g+1]),
      .act_o   (act[g])
    );
  end

  // Terminal position past the last cell holds no entry
  assign end_e         = ctl.start ? 1'b0 : end_q;
  assign act[MASK_LEN] = adv[MASK_LEN] || (!ctl.step && end_e) || eps[MASK_LEN];

  assign hit = act[len_q] && !ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pos_q       <= '0;
      esc_q       <= 1'b0;
      ovf_q       <= 1'b0;
      lrun_q      <= 1'b0;
      closed_q    <= 1'b0;
      frun_q      <= 1'b0;
      name_q      <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      esc_q    <= esc_d;
      ovf_q    <= ovf_d;
      lrun_q   <= lrun_d;
      closed_q <= closed_d;
      frun_q   <= frun_d;
      name_q   <= name_d;
      if (ctl.upd) begin
        end_q <= act[MASK_LEN];
      end
      // hold a result until taken; refill in the same cycle it leaves
      if (acc && req_type_i && is_last_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && req_type_i && is_last_i) begin
      matched_q <= hit;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign matched_o       = matched_q;
  assign mask_overflow_o = ovf_out_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iwm_pkg::*;

  localparam int unsigned MASK_LEN  = 64;
  localparam int unsigned HOLD_CYC  = 300;  // long result stall
  localparam int unsigned SETTLE    = 6;    // settling wait after draining; the result is registered
  localparam int unsigned RAND_REQS = 670;

  typedef logic [CHAR_W-1:0] text_t [$];
  typedef iwm_entry_t pat_t [$];

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              req_type_i;
  logic [CHAR_W-1:0] char_code_i;
  logic              is_last_i;
  logic              is_empty_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              matched_o;
  logic              mask_overflow_o;

  irc_wildcard_mask_match_unit #(
    .MASK_LEN(MASK_LEN)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .char_code_i    (char_code_i),
    .is_last_i      (is_last_i),
    .is_empty_i     (is_empty_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .matched_o      (matched_o),
    .mask_overflow_o(mask_overflow_o)
  );

  always #4 clk_i = ~clk_i;

  // Matcher state kept by the testbench: decoded mask and the active-cell row
  iwm_entry_t        pat_mem [MASK_LEN];
  int unsigned       pat_len;
  bit                esc_wait;
  bit                ovf_seen;
  bit                name_open;
  bit                pat_closed;
  logic [MASK_LEN:0] live;

  verdict_t verdict_q [$];

  int unsigned sent_cnt;
  int unsigned err_cnt = 0;
  bit          tx_burst;
  bit          rx_burst;
  bit          hold_req;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_OFS) : c;
  endfunction

  // A run cell lets the match slide past it without consuming a character
  function automatic void spread_runs();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pat_mem[i].kind == KIND_RUN) live[i+1] = 1'b1;
    end
  endfunction

  function automatic void push_position(input iwm_entry_t e);
    if (pat_len >= MASK_LEN) begin
      ovf_seen = 1'b1;
    end else begin
      pat_mem[pat_len] = e;
      pat_len++;
    end
  endfunction

  function automatic void clear_matcher();
    pat_len    = 0;
    esc_wait   = 1'b0;
    ovf_seen   = 1'b0;
    name_open  = 1'b0;
    pat_closed = 1'b0;
    live       = '0;
    live[0]    = 1'b1;
  endfunction

  // Apply one accepted request; queue a verdict when a name ends
  function automatic void advance_matcher(input logic typ, input logic [CHAR_W-1:0] ch,
                                          input logic last, input logic empty);
    logic [MASK_LEN:0] nxt;
    logic [CHAR_W-1:0] c;
    verdict_t          v;
    c = lower_byte(ch);
    if (!typ) begin
      // A mask request drops any name in flight and opens a new mask after a closed one
      name_open = 1'b0;
      if (pat_closed) begin
        pat_len    = 0;
        esc_wait   = 1'b0;
        ovf_seen   = 1'b0;
        pat_closed = 1'b0;
      end
      if (!empty) begin
        if (esc_wait) begin
          esc_wait = 1'b0;
          push_position(iwm_entry_t'{kind: KIND_LIT, chr: c});
        end else if (ch == CHAR_BSLASH) begin
          esc_wait = 1'b1;
        end else if (ch == CHAR_STAR) begin
          push_position(iwm_entry_t'{kind: KIND_RUN, chr: '0});
        end else if (ch == CHAR_QUEST) begin
          push_position(iwm_entry_t'{kind: KIND_ONE, chr: '0});
        end else begin
          push_position(iwm_entry_t'{kind: KIND_LIT, chr: c});
        end
      end
      if (last) begin
        esc_wait   = 1'b0;  // a dangling backslash matches nothing
        pat_closed = 1'b1;
      end
      return;
    end
    if (!name_open) begin
      live      = '0;
      live[0]   = 1'b1;
      spread_runs();
      name_open = 1'b1;
    end
    if (!empty) begin
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
        if (live[i]) begin
          case (pat_mem[i].kind)
            KIND_RUN: begin
              nxt[i]   = 1'b1;
              nxt[i+1] = 1'b1;
            end
            KIND_ONE: nxt[i+1] = 1'b1;
            default:  if (pat_mem[i].chr == c) nxt[i+1] = 1'b1;
          endcase
        end
      end
      live = nxt;
      spread_runs();
    end
    if (last) begin
      v.matched  = live[pat_len] && !ovf_seen;
      v.overflow = ovf_seen;
      verdict_q.push_back(v);
      name_open = 1'b0;
      live      = '0;
      live[0]   = 1'b1;
    end
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input logic typ, input logic [CHAR_W-1:0] ch,
                          input logic last, input logic empty);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= typ;
    char_code_i <= ch;
    is_last_i   <= last;
    is_empty_i  <= empty;
    do @(posedge clk_i); while (!in_ready_o);
    advance_matcher(typ, ch, last, empty);
    sent_cnt++;
  endtask

  task automatic put_text(input logic typ, input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_req(typ, s[i], i == s.len() - 1, 1'b0);
    end
  endtask

  // Send a string with stray empty requests mixed in; end it on the last
  // character or on a separate empty request, or leave it open
  task automatic send_string(input logic typ, input text_t s, input bit finish);
    bit tail_empty;
    tail_empty = (s.size() == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < s.size(); i++) begin
      if ($urandom_range(0, 14) == 0) send_req(typ, 8'($urandom), 1'b0, 1'b1);
      send_req(typ, s[i], finish && !tail_empty && (i == s.size() - 1), 1'b0);
    end
    if (finish && tail_empty) send_req(typ, 8'($urandom), 1'b1, 1'b1);
  endtask

  // Drop valid, wait for every pending verdict, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] swap_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    lc = c | CASE_OFS;
    return (lc >= "a" && lc <= "z") ? (c ^ CASE_OFS) : c;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 3) == 0) begin
      c = 8'($urandom);
    end else begin
      c = 8'("a" + $urandom_range(0, 2));
      if ($urandom_range(0, 1) != 0) c = swap_case(c);
    end
    return c;
  endfunction

  function automatic iwm_entry_t rand_entry();
    iwm_entry_t e;
    e.kind = KIND_LIT;
    e.chr  = '0;
    case ($urandom_range(0, 9))
      0, 1: e.kind = KIND_RUN;
      2:    e.kind = KIND_ONE;
      3:    e.chr = 8'($urandom);
      4: begin
        case ($urandom_range(0, 2))
          0:       e.chr = CHAR_STAR;
          1:       e.chr = CHAR_QUEST;
          default: e.chr = CHAR_BSLASH;
        endcase
      end
      default: e.chr = pick_char();
    endcase
    return e;
  endfunction

  // Build a name that follows the pattern, then maybe break it
  function automatic text_t name_from(input pat_t p);
    text_t       w;
    int unsigned k;
    foreach (p[i]) begin
      case (p[i].kind)
        KIND_RUN: repeat ($urandom_range(0, 3)) w.push_back(pick_char());
        KIND_ONE: w.push_back(8'($urandom));
        default:  w.push_back($urandom_range(0, 1) ? swap_case(p[i].chr) : p[i].chr);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, w.size());
      case ($urandom_range(0, 2))
        0:       if (w.size() != 0) w.delete(k % w.size());
        1:       w.insert(k, pick_char());
        default: if (w.size() != 0) w[k % w.size()] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  // Mixed case, any byte against '?', escaped star after a literal
  task automatic test_fold_and_escape();
    put_text(1'b0, "a?\\*");
    send_req(1'b1, "A", 1'b0, 1'b0);
    send_req(1'b1, 8'hFF, 1'b0, 1'b0);
    send_req(1'b1, CHAR_STAR, 1'b1, 1'b0);
    drain_results();
  endtask

  // Backslash at the end of the mask, and a bracket that must not fold
  task automatic test_trailing_backslash();
    put_text(1'b0, "[*\\");
    send_req(1'b1, "{", 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_empty_strings();
    // star-only mask with a stray empty request in front
    send_req(1'b0, 8'h00, 1'b0, 1'b1);
    send_req(1'b0, CHAR_STAR, 1'b1, 1'b0);
    send_req(1'b1, 8'hFF, 1'b0, 1'b1);
    send_req(1'b1, 8'hFF, 1'b1, 1'b1);
    // empty mask: only the empty name matches
    send_req(1'b0, 8'hFF, 1'b1, 1'b1);
    send_req(1'b1, 8'h00, 1'b1, 1'b0);
    send_req(1'b1, 8'h00, 1'b1, 1'b1);
    drain_results();
  endtask

  task automatic test_cancel_and_early_name();
    put_text(1'b0, "b");
    send_req(1'b1, "b", 1'b0, 1'b0);
    send_req(1'b0, "c", 1'b1, 1'b0);  // drops the open name, starts mask "c"
    send_req(1'b1, "C", 1'b1, 1'b0);
    send_req(1'b0, "x", 1'b0, 1'b0);  // mask left open
    send_req(1'b1, "X", 1'b1, 1'b0);  // name sees only the positions so far
    send_req(1'b0, "y", 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_random_glob(input int unsigned target);
    pat_t        pat;
    text_t       raw;
    text_t       head;
    text_t       rest;
    int unsigned npos;
    int unsigned split;
    while (sent_cnt < target) begin
      pat.delete();
      raw.delete();
      head.delete();
      rest.delete();
      tx_burst = ($urandom_range(0, 5) == 0);
      rx_burst = ($urandom_range(0, 5) == 0);
      // Mostly short masks; now and then one near or past capacity
      npos = ($urandom_range(0, 20) == 0) ? $urandom_range(MASK_LEN - 4, MASK_LEN + 6)
                                          : $urandom_range(0, 8);
      repeat (npos) pat.push_back(rand_entry());
      foreach (pat[i]) begin
        case (pat[i].kind)
          KIND_RUN: raw.push_back(CHAR_STAR);
          KIND_ONE: raw.push_back(CHAR_QUEST);
          default: begin
            if (pat[i].chr == CHAR_STAR || pat[i].chr == CHAR_QUEST ||
                pat[i].chr == CHAR_BSLASH || $urandom_range(0, 7) == 0) begin
              raw.push_back(CHAR_BSLASH);
            end
            raw.push_back(pat[i].chr);
          end
        endcase
      end
      if ($urandom_range(0, 9) == 0) raw.push_back(CHAR_BSLASH);
      // Sometimes stream a name while the mask is still open
      split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, raw.size()) : raw.size();
      foreach (raw[i]) begin
        if (i < split) head.push_back(raw[i]);
        else rest.push_back(raw[i]);
      end
      send_string(1'b0, head, split == raw.size());
      if (split != raw.size()) begin
        send_string(1'b1, name_from(pat), 1'b1);
        send_string(1'b0, rest, 1'b1);
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          head.delete();
          repeat ($urandom_range(0, 6)) head.push_back(pick_char());
          send_string(1'b1, head, 1'b1);
        end else begin
          send_string(1'b1, name_from(pat), 1'b1);
        end
      end
      // Leave a name open so the next mask cancels it
      if ($urandom_range(0, 9) == 0) send_string(1'b1, name_from(pat), 1'b0);
      if ($urandom_range(0, 11) == 0) drain_results();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    drain_results();
  endtask

  // Stall the result side for a long stretch while requests keep coming
  task automatic test_result_stall();
    text_t s;
    s.push_back(CHAR_QUEST);
    send_string(1'b0, s, 1'b1);
    drain_results();
    tx_burst = 1'b1;
    hold_req = 1'b1;
    repeat (30) begin
      s.delete();
      s.push_back(8'($urandom));
      send_string(1'b1, s, 1'b1);
    end
    tx_burst = 1'b0;
    drain_results();
  endtask

  // Result side: random stalls per result, plus the long hold on request
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !held) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        held = 1'b1;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every taken result against the oldest pending verdict
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result matched=%0b overflow=%0b",
                                  matched_o, mask_overflow_o));
      end else begin
        want = verdict_q.pop_front();
        if (matched_o !== want.matched) begin
          report_mismatch($sformatf("matched got %0b want %0b", matched_o, want.matched));
        end
        if (mask_overflow_o !== want.overflow) begin
          report_mismatch($sformatf("mask_overflow got %0b want %0b",
                                    mask_overflow_o, want.overflow));
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("irc_wildcard_mask_match_unit test failed");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= 1'b0;
    char_code_i <= '0;
    is_last_i   <= 1'b0;
    is_empty_i  <= 1'b0;
    sent_cnt = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_req = 1'b0;
    clear_matcher();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fold_and_escape();
    test_trailing_backslash();
    test_empty_strings();
    test_cancel_and_early_name();
    test_random_glob(RAND_REQS);
    test_result_stall();
    drain_results();

    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("irc_wildcard_mask_match_unit test passed");
    end else begin
      $display("irc_wildcard_mask_match_unit test failed");
    end
    $finish;
  end

endmodule
